// ----- design/jhsp_pkg.sv -----
// Shared types and constants of the JPEG header segment parser.
package jhsp_pkg;

   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   typedef enum logic [3:0] {
      KIND_QT_HEAD    = 4'd0,
      KIND_QT_BYTE    = 4'd1,
      KIND_PRECISION  = 4'd2,
      KIND_HEIGHT     = 4'd3,
      KIND_WIDTH      = 4'd4,
      KIND_COMP_COUNT = 4'd5,
      KIND_COMP       = 4'd6,
      KIND_HT_HEAD    = 4'd7,
      KIND_HT_COUNT   = 4'd8,
      KIND_HT_VALUE   = 4'd9,
      KIND_SCAN_COUNT = 4'd10,
      KIND_SCAN_COMP  = 4'd11,
      KIND_SCAN_BYTE  = 4'd12,
      KIND_END        = 4'd13,
      KIND_ERROR      = 4'd14
   } kind_type;

   typedef enum logic [1:0] {
      ERR_BAD_START = 2'd0,
      ERR_EARLY_END = 2'd1,
      ERR_NO_END    = 2'd2,
      ERR_SHORT_LEN = 2'd3
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  upper;
      logic [3:0]  lower;
      logic [11:0] position;
      logic [15:0] value;
      logic [7:0]  qsel;
      err_type     err;
      logic        last;
   } rec_type;

   // Records produced by one byte, handed from the parser to the queue.
   typedef struct packed {
      logic    valid;
      logic    two;
      rec_type rec0;
      rec_type rec1;
   } push_type;

endpackage

// ----- design/jhsp_if.sv -----
// Channel interfaces: byte input and record output.
interface jhsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_last;

   modport source (output valid, data_byte, stream_last, input ready);
   modport sink   (input valid, data_byte, stream_last, output ready);
endinterface

interface jhsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  record_kind;
   logic [4:0]  upper_nibble;
   logic [3:0]  lower_nibble;
   logic [11:0] position;
   logic [15:0] field_value;
   logic [7:0]  quant_select;
   logic [1:0]  error_code;
   logic        last_of_run;

   modport source (output valid, record_kind, upper_nibble, lower_nibble, position,
                   field_value, quant_select, error_code, last_of_run, input ready);
   modport sink   (input valid, record_kind, upper_nibble, lower_nibble, position,
                   field_value, quant_select, error_code, last_of_run, output ready);
endinterface

// ----- design/jhsp_parser.sv -----
// Marker/segment state machine: decodes one byte per step into up to two records.
module jhsp_parser
   import jhsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output push_type   push
);

   typedef enum logic [3:0] {
      PH_START0, PH_START1, PH_HUNT0, PH_HUNT1, PH_MK0,
      PH_MK1, PH_LEN0, PH_LEN1, PH_PAY, PH_SCAN
   } phase_type;

   typedef enum logic [2:0] {
      SK_SKIP, SK_DQT, SK_SOF, SK_DHT, SK_SOS
   } seg_type;

   typedef struct packed {
      phase_type   phase;
      seg_type     seg;
      logic [15:0] remaining;
      logic [15:0] offset;
      logic [7:0]  held;
      logic [7:0]  comp_total;
      logic [7:0]  comp_idx;
      logic [1:0]  sub_step;
      logic [11:0] ht_total;
      logic [7:0]  pend;
      logic        pend_valid;
   } state_type;

   localparam logic [15:0] MarkerEoi = 16'hFFD9;
   localparam logic [15:0] MarkerDqt = 16'hFFDB;
   localparam logic [15:0] MarkerSof = 16'hFFC0;
   localparam logic [15:0] MarkerDht = 16'hFFC4;
   localparam logic [15:0] MarkerSos = 16'hFFDA;
   localparam logic [7:0]  ByteFf    = 8'hFF;
   localparam logic [7:0]  ByteSoi   = 8'hD8;
   localparam logic [7:0]  ByteEoi   = 8'hD9;
   localparam state_type   StateReset = '{phase: PH_START0, seg: SK_SKIP, default: '0};

   state_type   state_ff, state_in;
   rec_type     main_rec, extra_rec, rec0, rec1;
   logic        main_valid, extra_valid;
   logic        errored, ended;
   logic [15:0] word16, o, o_m1, o_m17;

   always_comb begin
      state_in    = state_ff;
      main_rec    = '0;
      extra_rec   = '0;
      main_valid  = 1'b0;
      extra_valid = 1'b0;
      errored     = 1'b0;
      ended       = 1'b0;
      word16      = {state_ff.held, in_byte};
      o           = state_ff.offset;
      o_m1        = o - 16'd1;
      o_m17       = o - 16'd17;

      case (state_ff.phase)
         PH_START0: begin
            if (in_byte == ByteFf) begin
               state_in.phase = PH_START1;
            end else begin
               main_valid     = 1'b1;
               main_rec.kind  = KIND_ERROR;
               main_rec.err   = ERR_BAD_START;
               errored        = 1'b1;
               state_in.phase = PH_HUNT0;
            end
         end
         PH_START1: begin
            if (in_byte == ByteSoi) begin
               state_in.phase = PH_MK0;
            end else begin
               main_valid     = 1'b1;
               main_rec.kind  = KIND_ERROR;
               main_rec.err   = ERR_BAD_START;
               errored        = 1'b1;
               state_in.phase = (in_byte == ByteFf) ? PH_HUNT1 : PH_HUNT0;
            end
         end
         PH_HUNT0: begin
            state_in.phase = (in_byte == ByteFf) ? PH_HUNT1 : PH_HUNT0;
         end
         PH_HUNT1: begin
            if (in_byte == ByteSoi) begin
               state_in.phase = PH_MK0;
            end else begin
               state_in.phase = (in_byte == ByteFf) ? PH_HUNT1 : PH_HUNT0;
            end
         end
         PH_MK0: begin
            state_in.held  = in_byte;
            state_in.phase = PH_MK1;
         end
         PH_MK1: begin
            if (word16 == MarkerEoi) begin
               main_valid     = 1'b1;
               main_rec.kind  = KIND_ERROR;
               main_rec.err   = ERR_EARLY_END;
               errored        = 1'b1;
               state_in.phase = PH_HUNT0;
            end else begin
               case (word16)
                  MarkerDqt: state_in.seg = SK_DQT;
                  MarkerSof: state_in.seg = SK_SOF;
                  MarkerDht: state_in.seg = SK_DHT;
                  MarkerSos: state_in.seg = SK_SOS;
                  default:   state_in.seg = SK_SKIP;
               endcase
               state_in.phase = PH_LEN0;
            end
         end
         PH_LEN0: begin
            state_in.held  = in_byte;
            state_in.phase = PH_LEN1;
         end
         PH_LEN1: begin
            if (word16 == 16'd1) begin
               main_valid     = 1'b1;
               main_rec.kind  = KIND_ERROR;
               main_rec.err   = ERR_SHORT_LEN;
               errored        = 1'b1;
               state_in.phase = PH_HUNT0;
            end else if (word16 <= 16'd2) begin
               // empty segment: straight to next marker or scan data
               if (state_ff.seg == SK_SOS) begin
                  state_in.phase      = PH_SCAN;
                  state_in.pend_valid = 1'b0;
                  state_in.offset     = '0;
               end else begin
                  state_in.phase = PH_MK0;
               end
            end else begin
               state_in.remaining  = word16 - 16'd2;
               state_in.offset     = '0;
               state_in.comp_total = '0;
               state_in.comp_idx   = '0;
               state_in.sub_step   = '0;
               state_in.ht_total   = '0;
               state_in.phase      = PH_PAY;
            end
         end
         PH_PAY: begin
            case (state_ff.seg)
               SK_DQT: begin
                  main_valid = 1'b1;
                  if (o == 16'd0) begin
                     main_rec.kind  = KIND_QT_HEAD;
                     main_rec.upper = {1'b0, in_byte[7:4]} + 5'd1;
                     main_rec.lower = in_byte[3:0];
                  end else begin
                     main_rec.kind     = KIND_QT_BYTE;
                     main_rec.position = (o_m1 > 16'd4095) ? 12'd4095 : o_m1[11:0];
                     main_rec.value    = {8'd0, in_byte};
                  end
               end
               SK_SOF: begin
                  if (o == 16'd0) begin
                     main_valid     = 1'b1;
                     main_rec.kind  = KIND_PRECISION;
                     main_rec.value = {8'd0, in_byte};
                  end else if (o == 16'd1 || o == 16'd3) begin
                     state_in.held = in_byte;
                  end else if (o == 16'd2 || o == 16'd4) begin
                     main_valid     = 1'b1;
                     main_rec.kind  = (o == 16'd2) ? KIND_HEIGHT : KIND_WIDTH;
                     main_rec.value = word16;
                  end else if (o == 16'd5) begin
                     main_valid          = 1'b1;
                     main_rec.kind       = KIND_COMP_COUNT;
                     main_rec.value      = {8'd0, in_byte};
                     state_in.comp_total = in_byte;
                     state_in.sub_step   = '0;
                     state_in.comp_idx   = '0;
                  end else if (state_ff.comp_idx < state_ff.comp_total) begin
                     // three bytes per component: id, sampling, table
                     case (state_ff.sub_step)
                        2'd0: state_in.held = in_byte;
                        2'd1: state_in.pend = in_byte;
                        default: begin
                           main_valid        = 1'b1;
                           main_rec.kind     = KIND_COMP;
                           main_rec.upper    = {1'b0, state_ff.pend[7:4]};
                           main_rec.lower    = state_ff.pend[3:0];
                           main_rec.position = {4'd0, state_ff.comp_idx};
                           main_rec.value    = {8'd0, state_ff.held};
                           main_rec.qsel     = in_byte;
                        end
                     endcase
                     if (state_ff.sub_step == 2'd2) begin
                        state_in.sub_step = 2'd0;
                        state_in.comp_idx = state_ff.comp_idx + 8'd1;
                     end else begin
                        state_in.sub_step = state_ff.sub_step + 2'd1;
                     end
                  end
               end
               SK_DHT: begin
                  if (o == 16'd0) begin
                     main_valid     = 1'b1;
                     main_rec.kind  = KIND_HT_HEAD;
                     main_rec.upper = {1'b0, in_byte[7:4]};
                     main_rec.lower = in_byte[3:0];
                  end else if (o <= 16'd16) begin
                     main_valid        = 1'b1;
                     main_rec.kind     = KIND_HT_COUNT;
                     main_rec.position = o_m1[11:0];
                     main_rec.value    = {8'd0, in_byte};
                     state_in.ht_total = state_ff.ht_total + {4'd0, in_byte};
                  end else if (o_m17 < {4'd0, state_ff.ht_total}) begin
                     main_valid        = 1'b1;
                     main_rec.kind     = KIND_HT_VALUE;
                     main_rec.position = o_m17[11:0];
                     main_rec.value    = {8'd0, in_byte};
                  end
               end
               SK_SOS: begin
                  if (o == 16'd0) begin
                     main_valid          = 1'b1;
                     main_rec.kind       = KIND_SCAN_COUNT;
                     main_rec.value      = {8'd0, in_byte};
                     state_in.comp_total = in_byte;
                     state_in.sub_step   = '0;
                     state_in.comp_idx   = '0;
                  end else if (state_ff.comp_idx < state_ff.comp_total) begin
                     if (state_ff.sub_step == 2'd0) begin
                        state_in.held     = in_byte;
                        state_in.sub_step = 2'd1;
                     end else begin
                        main_valid        = 1'b1;
                        main_rec.kind     = KIND_SCAN_COMP;
                        main_rec.upper    = {1'b0, in_byte[7:4]};
                        main_rec.lower    = in_byte[3:0];
                        main_rec.position = {4'd0, state_ff.comp_idx};
                        main_rec.value    = {8'd0, state_ff.held};
                        state_in.sub_step = 2'd0;
                        state_in.comp_idx = state_ff.comp_idx + 8'd1;
                     end
                  end
               end
               default: ;
            endcase
            state_in.offset    = o + 16'd1;
            state_in.remaining = state_ff.remaining - 16'd1;
            if (state_ff.remaining == 16'd1) begin
               if (state_ff.seg == SK_SOS) begin
                  state_in.phase      = PH_SCAN;
                  state_in.pend_valid = 1'b0;
                  state_in.offset     = '0;
               end else begin
                  state_in.phase = PH_MK0;
               end
            end
         end
         default: begin
            // scan data: one byte held back so FF D9 is never passed on
            if (state_ff.pend_valid && state_ff.pend == ByteFf && in_byte == ByteEoi) begin
               main_valid    = 1'b1;
               main_rec.kind = KIND_END;
               ended         = 1'b1;
            end else begin
               if (state_ff.pend_valid) begin
                  main_valid        = 1'b1;
                  main_rec.kind     = KIND_SCAN_BYTE;
                  main_rec.position = o[11:0];
                  main_rec.value    = {8'd0, state_ff.pend};
                  if (o < 16'd4095) begin
                     state_in.offset = o + 16'd1;
                  end
               end
               state_in.pend       = in_byte;
               state_in.pend_valid = 1'b1;
               if (in_last) begin
                  extra_valid   = 1'b1;
                  extra_rec.kind = KIND_ERROR;
                  extra_rec.err  = ERR_NO_END;
               end
            end
         end
      endcase

      // truncation before the scan data
      if (in_last && !errored && state_ff.phase != PH_HUNT0 &&
          state_ff.phase != PH_HUNT1 && state_ff.phase != PH_SCAN) begin
         extra_valid    = 1'b1;
         extra_rec.kind = KIND_ERROR;
         extra_rec.err  = ERR_EARLY_END;
      end

      if (in_last || ended) begin
         state_in = StateReset;
      end

      rec0 = main_valid ? main_rec : extra_rec;
      rec1 = extra_rec;
      if (main_valid && extra_valid) begin
         rec1.last = 1'b1;
      end else begin
         rec0.last = 1'b1;
      end

      push.valid = step && (main_valid || extra_valid);
      push.two   = main_valid && extra_valid;
      push.rec0  = rec0;
      push.rec1  = rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && in_last) |=> state_ff.phase == PH_START0)
      else $error("parser did not return to start after final byte");

endmodule

// ----- design/jhsp_rec_fifo.sv -----
// Record queue: takes one or two records per cycle, gives one per cycle while out_ready is high.
module jhsp_rec_fifo
   import jhsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rec_type  out_rec
);

   rec_type               mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   count_ff, count_in;
   logic [FifoPtrW-1:0]   wr_ptr_next;
   logic [FifoCntW-1:0]   push_n;
   logic                  pop;

   assign out_valid   = count_ff != '0;
   assign out_rec     = mem_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   assign room        = count_ff <= FifoCntW'(FifoDepth - 2);
   assign wr_ptr_next = wr_ptr_ff + FifoPtrW'(1);
   assign push_n      = !push.valid ? '0 : (push.two ? FifoCntW'(2) : FifoCntW'(1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[FifoPtrW-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + FifoPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - (pop ? FifoCntW'(1) : FifoCntW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.rec0;
         if (push.two) begin
            mem_ff[wr_ptr_next] <= push.rec1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FifoCntW'(FifoDepth))
      else $error("record queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> room)
      else $error("records pushed without room");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.two ? (push.rec1.last && !push.rec0.last) : push.rec0.last))
      else $error("last-of-run flag misplaced");

endmodule

// ----- design/jpeg_header_segment_parser.sv -----
// Top level of the JPEG header segment parser.
// Takes a JPEG file one word (byte) per clock on req_bus and returns field
// records on rsp_bus. Throughput is one byte per clock as long as rsp_bus
// drains; a byte that yields two records (a record plus a truncation error)
// hands them to rsp_bus one after the other, and that output port is the
// only thing that sets the sustained rate. A byte is captured in an input
// register, decoded by the marker/segment state machine once the queue has
// room for two more records, and its records are written into a four-entry
// record queue whose head drives rsp_bus. The input side keeps taking bytes
// while results wait, as long as the queue has room for two more records.
// last_of_run marks the final record of each byte. After the end record or
// a byte with stream_last, the parser starts over and expects a new FF D8.
module jpeg_header_segment_parser
   import jhsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jhsp_req_if.sink   req_bus,
   jhsp_rsp_if.source rsp_bus
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       accept, advance;

   push_type   push;
   logic       room;
   rec_type    head;

   assign advance       = s1_valid_ff && room;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.stream_last;
      end
   end

   jhsp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (s1_byte_ff),
      .in_last (s1_last_ff),
      .push    (push)
   );

   jhsp_rec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_rec   (head)
   );

   assign rsp_bus.record_kind  = head.kind;
   assign rsp_bus.upper_nibble = head.upper;
   assign rsp_bus.lower_nibble = head.lower;
   assign rsp_bus.position     = head.position;
   assign rsp_bus.field_value  = head.value;
   assign rsp_bus.quant_select = head.qsel;
   assign rsp_bus.error_code   = head.err;
   assign rsp_bus.last_of_run  = head.last;

endmodule

// ----- verif/jpeg_header_segment_parser_tb.sv -----
// Self-checking testbench for the JPEG header segment parser.
module jpeg_header_segment_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jhsp_pkg::*;

   // Watchdog: cycles in a row with no word moving on either channel.
   localparam int STALL_LIMIT   = 2000;
   // Input register plus record queue; enough for a silent byte to settle.
   localparam int SETTLE_CYCLES = 8;

   // Marker codes
   localparam logic [15:0] MARK_SOI  = 16'hFFD8;
   localparam logic [15:0] MARK_EOI  = 16'hFFD9;
   localparam logic [15:0] MARK_DQT  = 16'hFFDB;
   localparam logic [15:0] MARK_SOF0 = 16'hFFC0;
   localparam logic [15:0] MARK_DHT  = 16'hFFC4;
   localparam logic [15:0] MARK_SOS  = 16'hFFDA;
   localparam logic [15:0] MARK_COM  = 16'hFFFE;

   // Parse phases and segment kinds of the predictor.
   typedef enum logic [3:0] {
      PH_WAIT_FF, PH_WAIT_D8, PH_HUNT_FF, PH_HUNT_D8, PH_MARK_HI,
      PH_MARK_LO, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_SCAN_DATA
   } parse_phase_type;

   typedef enum logic [2:0] {SEG_SKIP, SEG_DQT, SEG_SOF, SEG_DHT, SEG_SOS} segment_type;

   logic clock;
   logic reset;

   jhsp_req_if req_bus ();
   jhsp_rsp_if rsp_bus ();

   jpeg_header_segment_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state
   parse_phase_type phase;
   segment_type     seg;
   logic [15:0]  seg_left;
   logic [15:0]  seg_off;      // payload index, or scan byte count
   logic [7:0]   hold_byte;
   logic [7:0]   comp_total;
   logic [1:0]   comp_step;
   logic [11:0]  huff_total;
   logic [7:0]   scan_byte;    // also holds the sampling byte of a frame component
   logic         scan_held;

   rec_type      pending_records[$];   // records still owed by the block
   logic [7:0]   image_q[$];           // file under construction

   int failures           = 0;
   int items_sent         = 0;
   int idle_cycles        = 0;
   int hold_left          = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void reset_parse_state();
      phase      = PH_WAIT_FF;
      seg        = SEG_SKIP;
      seg_left   = '0;
      seg_off    = '0;
      hold_byte  = '0;
      comp_total = '0;
      comp_step  = '0;
      huff_total = '0;
      scan_byte  = '0;
      scan_held  = 1'b0;
   endfunction

   function automatic void add_record(kind_type k, int up = 0, int lo = 0, int pos = 0,
                                      int val = 0, int qs = 0, err_type e = ERR_BAD_START);
      rec_type r;
      r.kind     = k;
      r.upper    = up[4:0];
      r.lower    = lo[3:0];
      r.position = pos[11:0];
      r.value    = val[15:0];
      r.qsel     = qs[7:0];
      r.err      = e;
      r.last     = 1'b0;
      pending_records.push_back(r);
   endfunction

   // End of a segment's payload: a scan header opens the entropy data.
   function automatic void close_segment();
      if (seg == SEG_SOS) begin
         phase     = PH_SCAN_DATA;
         scan_held = 1'b0;
         seg_off   = '0;
      end else begin
         phase = PH_MARK_HI;
      end
   endfunction

   function automatic void decode_segment_byte(logic [7:0] b);
      int o;
      int c;
      o = seg_off;
      case (seg)
         SEG_DQT: begin
            if (o == 0) add_record(KIND_QT_HEAD, int'(b[7:4]) + 1, b[3:0]);
            else add_record(KIND_QT_BYTE, 0, 0, (o - 1 > 4095) ? 4095 : o - 1, b);
         end
         SEG_SOF: begin
            if (o == 0) begin
               add_record(KIND_PRECISION, 0, 0, 0, b);
            end else if (o == 1 || o == 3) begin
               hold_byte = b;
            end else if (o == 2 || o == 4) begin
               add_record((o == 2) ? KIND_HEIGHT : KIND_WIDTH, 0, 0, 0, {hold_byte, b});
            end else if (o == 5) begin
               add_record(KIND_COMP_COUNT, 0, 0, 0, b);
               comp_total = b;
               comp_step  = '0;
            end else begin
               // three bytes per component: id, sampling, table select
               c = (o - 6) / 3;
               if (c < int'(comp_total)) begin
                  if (comp_step == 0) hold_byte = b;
                  else if (comp_step == 1) scan_byte = b;
                  else add_record(KIND_COMP, scan_byte[7:4], scan_byte[3:0], c, hold_byte, b);
                  comp_step = (comp_step == 2) ? 2'd0 : comp_step + 2'd1;
               end
            end
         end
         SEG_DHT: begin
            if (o == 0) begin
               add_record(KIND_HT_HEAD, b[7:4], b[3:0]);
            end else if (o <= 16) begin
               add_record(KIND_HT_COUNT, 0, 0, o - 1, b);
               huff_total = huff_total + 12'(b);
            end else if (o - 17 < int'(huff_total)) begin
               add_record(KIND_HT_VALUE, 0, 0, o - 17, b);
            end
         end
         SEG_SOS: begin
            if (o == 0) begin
               add_record(KIND_SCAN_COUNT, 0, 0, 0, b);
               comp_total = b;
               comp_step  = '0;
            end else begin
               c = (o - 1) / 2;
               if (c < int'(comp_total)) begin
                  if (comp_step == 0) hold_byte = b;
                  else add_record(KIND_SCAN_COMP, b[7:4], b[3:0], c, hold_byte);
                  comp_step = comp_step ^ 2'd1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // One accepted input word: appends the records it causes.
   function automatic void parse_byte(logic [7:0] b, logic fin);
      parse_phase_type p;
      logic [15:0]  word;
      bit           errored;
      bit           ended;
      int           base;
      p       = phase;
      errored = 1'b0;
      ended   = 1'b0;
      base    = pending_records.size();
      case (p)
         PH_WAIT_FF: begin
            if (b == MARK_SOI[15:8]) begin
               phase = PH_WAIT_D8;
            end else begin
               add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_START);
               errored = 1'b1;
               phase   = PH_HUNT_FF;
            end
         end
         PH_WAIT_D8: begin
            if (b == MARK_SOI[7:0]) begin
               phase = PH_MARK_HI;
            end else begin
               add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_START);
               errored = 1'b1;
               phase   = (b == MARK_SOI[15:8]) ? PH_HUNT_D8 : PH_HUNT_FF;
            end
         end
         PH_HUNT_FF: phase = (b == MARK_SOI[15:8]) ? PH_HUNT_D8 : PH_HUNT_FF;
         PH_HUNT_D8: begin
            if (b == MARK_SOI[7:0]) phase = PH_MARK_HI;
            else phase = (b == MARK_SOI[15:8]) ? PH_HUNT_D8 : PH_HUNT_FF;
         end
         PH_MARK_HI: begin
            hold_byte = b;
            phase     = PH_MARK_LO;
         end
         PH_MARK_LO: begin
            word = {hold_byte, b};
            if (word == MARK_EOI) begin
               add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_EARLY_END);
               errored = 1'b1;
               phase   = PH_HUNT_FF;
            end else begin
               case (word)
                  MARK_DQT:  seg = SEG_DQT;
                  MARK_SOF0: seg = SEG_SOF;
                  MARK_DHT:  seg = SEG_DHT;
                  MARK_SOS:  seg = SEG_SOS;
                  default:   seg = SEG_SKIP;
               endcase
               phase = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            hold_byte = b;
            phase     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            word = {hold_byte, b};
            if (word == 16'd1) begin
               add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_SHORT_LEN);
               errored = 1'b1;
               phase   = PH_HUNT_FF;
            end else if (word <= 16'd2) begin
               close_segment();
            end else begin
               seg_left   = word - 16'd2;
               seg_off    = '0;
               comp_total = '0;
               comp_step  = '0;
               huff_total = '0;
               phase      = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            decode_segment_byte(b);
            seg_off  = seg_off + 16'd1;
            seg_left = seg_left - 16'd1;
            if (seg_left == 0) close_segment();
         end
         default: begin
            // entropy data: each byte goes out one word later, FF D9 ends it
            if (scan_held && scan_byte == MARK_EOI[15:8] && b == MARK_EOI[7:0]) begin
               add_record(KIND_END);
               ended = 1'b1;
            end else begin
               if (scan_held) begin
                  add_record(KIND_SCAN_BYTE, 0, 0, seg_off, scan_byte);
                  if (seg_off < 16'd4095) seg_off = seg_off + 16'd1;
               end
               scan_byte = b;
               scan_held = 1'b1;
               if (fin) begin
                  add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_NO_END);
                  errored = 1'b1;
               end
            end
         end
      endcase

      // file cut off anywhere between the start marker and the scan data
      if (fin && !errored && !ended && p != PH_HUNT_FF && p != PH_HUNT_D8 &&
          p != PH_SCAN_DATA)
         add_record(KIND_ERROR, 0, 0, 0, 0, 0, ERR_EARLY_END);

      if (fin || ended) reset_parse_state();

      if (pending_records.size() > base)
         pending_records[pending_records.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_record();
      rec_type want;
      if (pending_records.size() == 0) begin
         $error("record_kind: expected none, actual %0d", rsp_bus.record_kind);
         failures++;
      end else begin
         want = pending_records.pop_front();
         check_field("record_kind",  16'(want.kind),     16'(rsp_bus.record_kind));
         check_field("upper_nibble", 16'(want.upper),    16'(rsp_bus.upper_nibble));
         check_field("lower_nibble", 16'(want.lower),    16'(rsp_bus.lower_nibble));
         check_field("position",     16'(want.position), 16'(rsp_bus.position));
         check_field("field_value",  want.value,         rsp_bus.field_value);
         check_field("quant_select", 16'(want.qsel),     16'(rsp_bus.quant_select));
         check_field("error_code",   16'(want.err),      16'(rsp_bus.error_code));
         check_field("last_of_run",  16'(want.last),     16'(rsp_bus.last_of_run));
      end
   endfunction

   // Sample both channels at the rising edge; predict first, then compare.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            parse_byte(req_bus.data_byte, req_bus.stream_last);
         if (rsp_bus.valid && rsp_bus.ready)
            check_record();
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("FAIL jpeg_header_segment_parser");
               $finish;
            end
         end
      end
   end

   // Record sink: long hold-off when asked, random stalls otherwise.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Offer one word; returns at the edge where it is taken.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.stream_last <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_marker(input logic [15:0] m);
      send_byte(m[15:8], 1'b0);
      send_byte(m[7:0], 1'b0);
   endtask

   task automatic send_image(input bit fin);
      for (int i = 0; i < image_q.size(); i++)
         send_byte(image_q[i], fin && i == image_q.size() - 1);
   endtask

   // Idle the input until every owed record is in, then let the pipe settle.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_segment(logic [15:0] marker, logic [7:0] body[$]);
      int          mode;
      logic [15:0] len;
      mode = $urandom_range(0, 11);
      if (mode == 0) begin
         body.delete();
         len = 16'd0;          // zero length: next byte is already a marker
      end else if (mode == 1) begin
         body.delete();
         len = 16'd2;          // empty payload
      end else begin
         len = 16'(body.size() + 2);
      end
      image_q.push_back(marker[15:8]);
      image_q.push_back(marker[7:0]);
      image_q.push_back(len[15:8]);
      image_q.push_back(len[7:0]);
      foreach (body[i]) image_q.push_back(body[i]);
   endfunction

   function automatic void push_random_segment();
      logic [7:0]  body[$];
      logic [15:0] marker;
      int          pick;
      int          n;
      int          total;
      int          keep;
      pick = $urandom_range(0, 3);
      case (pick)
         0: begin
            marker = MARK_DQT;
            body.push_back(8'($urandom));
            n = $urandom_range(0, 8);
            repeat (n) body.push_back(8'($urandom));
         end
         1: begin
            marker = MARK_SOF0;
            repeat (5) body.push_back(8'($urandom));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            body.push_back(8'(n));
            n = $urandom_range(0, 3 * ((n > 3) ? 3 : n) + 4);
            repeat (n) body.push_back(8'($urandom));
         end
         2: begin
            marker = MARK_DHT;
            body.push_back(8'($urandom));
            total = 0;
            repeat (16) begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
               body.push_back(8'(n));
               total += n;
            end
            n = $urandom_range(0, total + 2);
            repeat (n) body.push_back(8'($urandom));
         end
         default: begin
            // usually a skipped segment; the block does not require FF as the marker high byte
            marker = {($urandom_range(0, 7) == 0) ? 8'($urandom) : MARK_COM[15:8],
                      8'($urandom)};
            n = $urandom_range(0, 5);
            repeat (n) body.push_back(8'($urandom));
         end
      endcase
      // cut tables short now and then
      if ((pick == 1 || pick == 2) && $urandom_range(0, 5) == 0) begin
         keep = $urandom_range(1, body.size() - 1);
         while (body.size() > keep) body.delete(body.size() - 1);
      end
      push_segment(marker, body);
   endfunction

   function automatic void push_scan_header();
      logic [7:0] body[$];
      int         n;
      n = $urandom_range(1, 3);
      body.push_back(8'(n));
      repeat (2 * n) body.push_back(8'($urandom));
      repeat (3) body.push_back(8'($urandom));     // spectral bytes, ignored
      push_segment(MARK_SOS, body);
   endfunction

   // Mostly well-formed files with random content; the rest broken ways.
   task automatic play_random_image();
      int variant;
      int n;
      int keep;
      bit fin;
      image_q.delete();
      variant = $urandom_range(0, 99);
      fin     = $urandom_range(0, 1);
      if (variant >= 90 && variant < 95) begin
         if ($urandom_range(0, 1)) begin
            image_q.push_back(8'($urandom_range(0, 254)));
         end else begin
            image_q.push_back(MARK_SOI[15:8]);
            image_q.push_back(8'($urandom_range(0, 215)));
         end
      end
      image_q.push_back(MARK_SOI[15:8]);
      image_q.push_back(MARK_SOI[7:0]);
      n = $urandom_range(0, 3);
      repeat (n) push_random_segment();
      if (variant >= 80 && variant < 85) begin
         image_q.push_back(MARK_EOI[15:8]);          // end marker before any scan
         image_q.push_back(MARK_EOI[7:0]);
      end else if (variant >= 85 && variant < 90) begin
         image_q.push_back(MARK_COM[15:8]);          // length of one
         image_q.push_back(MARK_COM[7:0]);
         image_q.push_back(8'h00);
         image_q.push_back(8'h01);
         n = $urandom_range(0, 3);
         repeat (n) image_q.push_back(8'($urandom));
      end else begin
         push_scan_header();
         n = $urandom_range(0, 24);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
               image_q.push_back(8'hFF);               // stuffed FF 00
               image_q.push_back(8'h00);
            end else begin
               image_q.push_back(8'($urandom));
            end
         end
         if (variant >= 95) begin
            fin = 1'b1;                                // scan cut off
         end else begin
            image_q.push_back(MARK_EOI[15:8]);
            image_q.push_back(MARK_EOI[7:0]);
         end
      end
      if (variant >= 70 && variant < 80) begin
         keep = $urandom_range(1, image_q.size() - 1);
         while (image_q.size() > keep) image_q.delete(image_q.size() - 1);
         fin = 1'b1;
      end
      send_image(fin);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Wrong first byte, then wrong second byte; stream_last while hunting
   // brings the parser back to the start quietly.
   task automatic test_bad_start();
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(MARK_SOI[15:8], 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_drained();
   endtask

   // A segment length of one is an error; the parser then hunts for FF D8.
   task automatic test_short_length();
      send_marker(MARK_SOI);
      send_marker(MARK_COM);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_drained();
   endtask

   // Length two skips straight on; zero-length scan header opens the data.
   // The last word both flushes the held byte and flags the missing end.
   task automatic test_zero_length_scan();
      send_marker(MARK_SOI);
      send_marker(MARK_COM);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_marker(MARK_SOS);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_drained();
   endtask

   // File ends on a marker byte before any scan.
   task automatic test_truncated_header();
      send_marker(MARK_SOI);
      send_byte(8'hFF, 1'b1);
      wait_drained();
   endtask

   // Sink holds off while scan words keep coming: queue fills, input stalls.
   task automatic test_record_backpressure();
      image_q.delete();
      image_q = {MARK_SOI[15:8], MARK_SOI[7:0], MARK_SOS[15:8], MARK_SOS[7:0], 8'h00, 8'h00};
      repeat (30) image_q.push_back(8'($urandom_range(0, 254)));
      image_q.push_back(MARK_EOI[15:8]);
      image_q.push_back(MARK_EOI[7:0]);
      @(posedge clock);
      hold_left = 300;
      send_image(1'b1);
      wait_drained();
   endtask

   // Random files under each idle pattern: none, sender, sink, both.
   task automatic test_random_images();
      int sender_pct[4]   = '{0, 55, 0, 16};
      int receiver_pct[4] = '{0, 0, 55, 16};
      int start;
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = sender_pct[ph];
         receiver_stall_pct = receiver_pct[ph];
         start = items_sent;
         while (items_sent - start < 80) play_random_image();
         wait_drained();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.stream_last = 1'b0;
      rsp_bus.ready       = 1'b0;
      reset_parse_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bad_start();
      test_short_length();
      test_zero_length_scan();
      test_truncated_header();
      test_record_backpressure();
      test_random_images();

      if (failures == 0)
         $display("PASS jpeg_header_segment_parser");
      else
         $display("FAIL jpeg_header_segment_parser");
      $finish;
   end

endmodule

// ----- files.f -----
design/jhsp_pkg.sv
design/jhsp_if.sv
design/jhsp_parser.sv
design/jhsp_rec_fifo.sv
design/jpeg_header_segment_parser.sv
verif/jpeg_header_segment_parser_tb.sv
